/* rtl/core/spectrum_screen_cell_renderer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros shared by the cell renderer RTL
// Each macro expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_SCREEN_CELL_RENDERER_MACROS_SVH
`define SPECTRUM_SCREEN_CELL_RENDERER_MACROS_SVH

// same-cycle implication
`define SSCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sscr_pkg.sv */
// ----------------------------------------------------------------------------
// sscr_pkg
// Shared types and constants of the screen cell renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package sscr_pkg;

  // register reset values
  localparam logic [14:0] FrameBaseReset = 15'd2118;
  localparam logic [7:0]  LineWordsReset = 8'd44;

  // register index codes (paddr[2])
  localparam logic RegFrameBase = 1'b0;
  localparam logic RegLineWords = 1'b1;

  // attribute area base in video memory
  localparam logic [12:0] AttrBase = 13'h1800;

  // last screen third of the walk
  localparam logic [1:0] ThirdLast = 2'd2;

  // default depth of the front/back queue
  localparam int QueueDepthDef = 2;

  typedef logic [3:0] colour_t;

  // one classified cell line travelling from front to back
  typedef struct packed {
    logic [7:0] pixel_byte;
    colour_t    ink;        // colour for a set bit, flash already applied
    colour_t    paper;      // colour for a clear bit
    logic [7:0] line;       // {third, char row, pixel line}
    logic [4:0] column;
    logic       last;
  } entry_t;

  // live configuration
  typedef struct packed {
    logic [14:0] frame_base;
    logic [7:0]  line_words;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/sscr_if.sv */
// ----------------------------------------------------------------------------
// sscr_if
// Valid/ready channels for cell items in and rendered words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sscr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic [7:0] attr_byte;
  logic       flash_phase;

  modport source (output valid, pixel_byte, attr_byte, flash_phase, input ready);
  modport sink   (input valid, pixel_byte, attr_byte, flash_phase, output ready);
endinterface

interface sscr_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] fb_index;
  logic [31:0] pixel_word;
  logic [12:0] bitmap_addr;
  logic [12:0] attr_addr;
  logic        frame_last;

  modport source (output valid, fb_index, pixel_word, bitmap_addr, attr_addr,
                  frame_last, input ready);
  modport sink   (input valid, fb_index, pixel_word, bitmap_addr, attr_addr,
                  frame_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/spectrum_screen_cell_renderer.sv */
// ----------------------------------------------------------------------------
// spectrum_screen_cell_renderer
// Path: an accepted item goes into the queue, then into the output register,
// which holds it on out_o until it is taken. Throughput: one item per cycle;
// the front takes an item each cycle the queue has room, and the back drains
// one per cycle into its output register while it is empty or being taken.
// Reset: walk counters to zero, queue and output empty, registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_screen_cell_renderer #(
  parameter int QueueDepth = sscr_pkg::QueueDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sscr_in_if.sink          in_i,
  sscr_out_if.source       out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sscr_pkg::*;

  cfg_t   cfg_q;
  logic   wr_en;
  logic   push, q_ready, q_valid, pop;
  entry_t push_entry, pop_entry;

  // register port
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_base <= FrameBaseReset;
      cfg_q.line_words <= LineWordsReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        RegFrameBase: cfg_q.frame_base <= pwdata[14:0];
        RegLineWords: cfg_q.line_words <= pwdata[7:0];
        default:      cfg_q <= cfg_q;
      endcase
    end
  end

  // read-back, low address bits ignored
  always_comb begin
    unique case (paddr[2])
      RegFrameBase: prdata = {17'd0, cfg_q.frame_base};
      RegLineWords: prdata = {24'd0, cfg_q.line_words};
      default:      prdata = '0;
    endcase
  end

  sscr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .push_o  (push),
    .entry_o (push_entry),
    .ready_i (q_ready)
  );

  sscr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .data_o  (pop_entry),
    .pop_i   (pop)
  );

  sscr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (q_valid),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

/* rtl/core/sscr_front.sv */
// ----------------------------------------------------------------------------
// sscr_front
// Accepts cell items, resolves ink/paper with flash and stamps walk position.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spectrum_screen_cell_renderer_macros.svh"

module sscr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  sscr_in_if.sink            in_i,
  output logic               push_o,
  output sscr_pkg::entry_t   entry_o,
  input  wire logic          ready_i
);
  import sscr_pkg::*;

  logic [1:0] third_q, third_d;
  logic [2:0] row_q, row_d;
  logic [4:0] col_q, col_d;
  logic [2:0] line_q, line_d;
  logic       swap;
  colour_t    ink, paper;

  assign in_i.ready = ready_i;
  assign push_o     = in_i.valid & ready_i;

  // colour resolution
  assign swap  = in_i.attr_byte[7] & in_i.flash_phase;
  assign ink   = {in_i.attr_byte[6], in_i.attr_byte[2:0]};
  assign paper = {in_i.attr_byte[6], in_i.attr_byte[5:3]};

  always_comb begin
    entry_o.pixel_byte = in_i.pixel_byte;
    entry_o.ink        = swap ? paper : ink;
    entry_o.paper      = swap ? ink : paper;
    entry_o.line       = {third_q, row_q, line_q};
    entry_o.column     = col_q;
    entry_o.last       = (third_q == ThirdLast) & (&row_q) & (&col_q) & (&line_q);
  end

  // walk counters: pixel line innermost, then column, char row, third
  always_comb begin
    third_d = third_q;
    row_d   = row_q;
    col_d   = col_q;
    line_d  = line_q;
    if (push_o) begin
      line_d = line_q + 3'd1;
      if (&line_q) begin
        col_d = col_q + 5'd1;
        if (&col_q) begin
          row_d = row_q + 3'd1;
          if (&row_q) begin
            third_d = (third_q == ThirdLast) ? 2'd0 : third_q + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      third_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
      line_q  <= '0;
    end else begin
      third_q <= third_d;
      row_q   <= row_d;
      col_q   <= col_d;
      line_q  <= line_d;
    end
  end

  `SSCR_ASSERT_NEXT(a_wrap_after_last, push_o && entry_o.last,
    (third_q == 2'd0) && (row_q == 3'd0) && (col_q == 5'd0) && (line_q == 3'd0),
    "walk did not wrap after last item")
  `SSCR_ASSERT_NOW(a_third_range, 1'b1, third_q != 2'd3,
    "third counter out of range")
  `SSCR_ASSERT_NEXT(a_hold_idle, !push_o, $stable({third_q, row_q, col_q, line_q}),
    "walk moved without an item")

endmodule

`default_nettype wire

/* rtl/core/sscr_queue.sv */
// ----------------------------------------------------------------------------
// sscr_queue
// Short register queue decoupling the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spectrum_screen_cell_renderer_macros.svh"

module sscr_queue #(
  parameter int Depth = sscr_pkg::QueueDepthDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire sscr_pkg::entry_t data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  output sscr_pkg::entry_t      data_o,
  input  wire logic             pop_i
);
  import sscr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and fill tracking
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `SSCR_ASSERT_NOW(a_no_overfill, push_i, ready_o, "push into full queue")
  `SSCR_ASSERT_NOW(a_no_underrun, pop_i, valid_o, "pop from empty queue")
  `SSCR_ASSERT_NEXT(a_pop_count, pop_i && !push_i, count_q == $past(count_q) - 1'b1,
    "fill count lost track on pop")

endmodule

`default_nettype wire

/* rtl/core/sscr_back.sv */
// ----------------------------------------------------------------------------
// sscr_back
// Renders the pixel word, works out addresses and holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sscr_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire sscr_pkg::cfg_t   cfg_i,
  input  wire logic             valid_i,
  input  wire sscr_pkg::entry_t entry_i,
  output logic                  pop_o,
  sscr_out_if.source            out_o
);
  import sscr_pkg::*;

  logic        valid_q, valid_d;
  logic [16:0] fb_index_q;
  logic [31:0] pixel_word_q, pixel_word_d;
  logic [12:0] bitmap_addr_q, attr_addr_q;
  logic        frame_last_q;
  logic [15:0] line_offset;
  logic [16:0] fb_index_d;

  // take a new item whenever the output slot is free or draining
  assign pop_o   = valid_i & (~valid_q | out_o.ready);
  assign valid_d = pop_o | (valid_q & ~out_o.ready);

  // framebuffer index: base + screen line * words per line + column
  assign line_offset = {8'd0, entry_i.line} * {8'd0, cfg_i.line_words};
  assign fb_index_d  = 17'(cfg_i.frame_base) + 17'(line_offset) + 17'(entry_i.column);

  // eight nibbles, byte swapped: byte m holds pixels 2m (high) and 2m+1 (low)
  always_comb begin
    pixel_word_d = '0;
    for (int p = 0; p < 8; p++) begin
      pixel_word_d[8*(p>>1) + 4 - 4*(p&1) +: 4] =
        entry_i.pixel_byte[7-p] ? entry_i.ink : entry_i.paper;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      fb_index_q    <= fb_index_d;
      pixel_word_q  <= pixel_word_d;
      bitmap_addr_q <= {entry_i.line[7:6], entry_i.line[2:0], entry_i.line[5:3],
                        entry_i.column};
      attr_addr_q   <= AttrBase + 13'({entry_i.line[7:6], entry_i.line[5:3],
                                       entry_i.column});
      frame_last_q  <= entry_i.last;
    end
  end

  assign out_o.valid       = valid_q;
  assign out_o.fb_index    = fb_index_q;
  assign out_o.pixel_word  = pixel_word_q;
  assign out_o.bitmap_addr = bitmap_addr_q;
  assign out_o.attr_addr   = attr_addr_q;
  assign out_o.frame_last  = frame_last_q;

endmodule

`default_nettype wire

/* tb/cell_word_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cell word checker
// Watches the cell item channel, the rendered word channel and the register
// port. Keeps its own copy of the screen walk and the registers, works out the
// word each accepted item should give, and compares words in order.
// ----------------------------------------------------------------------------

module cell_word_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cell items in
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  pixel_byte_i,
  input  logic [7:0]  attr_byte_i,
  input  logic        flash_phase_i,
  // rendered words out
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [16:0] fb_index_i,
  input  logic [31:0] pixel_word_i,
  input  logic [12:0] bitmap_addr_i,
  input  logic [12:0] attr_addr_i,
  input  logic        frame_last_i,
  // register port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  // status towards the top
  output int          mismatch_count_o,
  output int          pending_words_o
);
  import sscr_pkg::*;

  // video memory steps of the walk
  localparam int unsigned BlockStep     = 'h0800;
  localparam int unsigned RowStep       = 'h0020;
  localparam int unsigned LineStep      = 'h0100;
  localparam int unsigned AttrThirdStep = 'h0100;

  typedef struct packed {
    logic [16:0] fb_index;
    logic [31:0] pixel_word;
    logic [12:0] bitmap_addr;
    logic [12:0] attr_addr;
    logic        frame_last;
  } cell_word_t;

  cell_word_t  expected_words[$];
  int          mismatches = 0;
  int          pending    = 0;

  // register copy
  logic [14:0] frame_base;
  logic [7:0]  line_words;

  // walk position
  logic [1:0]  third;
  logic [2:0]  char_row;
  logic [4:0]  column;
  logic [2:0]  pix_line;

  assign mismatch_count_o = mismatches;
  assign pending_words_o  = pending;

  // eight nibbles, pixel 0 on top, then byte swapped
  function automatic logic [31:0] paint_pixels(input logic [7:0] bits,
                                               input logic [7:0] attr,
                                               input logic       phase);
    colour_t     ink;
    colour_t     paper;
    logic        swap;
    logic [31:0] w;
    int          k;
    ink   = {attr[6], attr[2:0]};
    paper = attr[6:3];
    swap  = attr[7] & phase;
    w     = '0;
    for (k = 7; k >= 0; k--) begin
      w = {w[27:0], (bits[k] ^ swap) ? ink : paper};
    end
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  // word expected at the current walk position
  function automatic cell_word_t predict_word(input logic [7:0] bits,
                                              input logic [7:0] attr,
                                              input logic       phase);
    cell_word_t  p;
    int unsigned t, r, c, l, lw, idx, baddr, aaddr;
    t  = third;
    r  = char_row;
    c  = column;
    l  = pix_line;
    lw = line_words;
    idx   = frame_base + (t * 8 + r) * 8 * lw + c + l * lw;
    baddr = t * BlockStep + r * RowStep + c + l * LineStep;
    aaddr = AttrBase + t * AttrThirdStep + r * RowStep + c;
    p.fb_index    = idx[16:0];
    p.pixel_word  = paint_pixels(bits, attr, phase);
    p.bitmap_addr = baddr[12:0];
    p.attr_addr   = aaddr[12:0];
    p.frame_last  = (third == ThirdLast) && (char_row == 3'd7) &&
                    (column == 5'd31) && (pix_line == 3'd7);
    return p;
  endfunction

  // pixel line innermost, then column, character row, third
  task automatic advance_walk();
    if (pix_line != 3'd7) begin
      pix_line = pix_line + 3'd1;
    end else begin
      pix_line = '0;
      if (column != 5'd31) begin
        column = column + 5'd1;
      end else begin
        column = '0;
        if (char_row != 3'd7) begin
          char_row = char_row + 3'd1;
        end else begin
          char_row = '0;
          third    = (third == ThirdLast) ? 2'd0 : third + 2'd1;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    cell_word_t want;
    if (!rst_ni) begin
      frame_base = FrameBaseReset;
      line_words = LineWordsReset;
      third      = '0;
      char_row   = '0;
      column     = '0;
      pix_line   = '0;
      expected_words.delete();
    end else begin
      // words out, compared against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word fb_index", 32'(fb_index_i), '0);
        end else begin
          want = expected_words.pop_front();
          if (fb_index_i !== want.fb_index)
            report_mismatch("fb_index", 32'(fb_index_i), 32'(want.fb_index));
          if (pixel_word_i !== want.pixel_word)
            report_mismatch("pixel_word", pixel_word_i, want.pixel_word);
          if (bitmap_addr_i !== want.bitmap_addr)
            report_mismatch("bitmap_addr", 32'(bitmap_addr_i), 32'(want.bitmap_addr));
          if (attr_addr_i !== want.attr_addr)
            report_mismatch("attr_addr", 32'(attr_addr_i), 32'(want.attr_addr));
          if (frame_last_i !== want.frame_last)
            report_mismatch("frame_last", 32'(frame_last_i), 32'(want.frame_last));
        end
      end
      // register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[2])
          RegFrameBase: frame_base = pwdata_i[14:0];
          RegLineWords: line_words = pwdata_i[7:0];
          default: ;
        endcase
      end
      // items in
      if (in_valid_i && in_ready_i) begin
        expected_words.push_back(predict_word(pixel_byte_i, attr_byte_i, flash_phase_i));
        advance_walk();
      end
    end
    pending = expected_words.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Screen cell renderer testbench
// Drives cell items and register writes into the renderer under several
// register settings and idling patterns, holds the output off once to fill the
// block, and finishes at the widest register settings. The checker beside the
// block does all the comparing.
// ----------------------------------------------------------------------------

module tb;
  import sscr_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int TotalItems  = 400;
  localparam int HoldCycles  = 80;
  localparam int SettleWait  = 4;
  localparam int DrainCycles = 8;
  localparam int PhaseItems  = 40;
  localparam int NumPhases   = 8;
  localparam int NumDirected = 20;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          items_sent = 0;
  int          cycles = 0;
  int          mismatches;
  int          pending;

  sscr_in_if  in_if ();
  sscr_out_if out_if ();

  spectrum_screen_cell_renderer u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  cell_word_checker u_chk (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_if.valid),
    .in_ready_i       (in_if.ready),
    .pixel_byte_i     (in_if.pixel_byte),
    .attr_byte_i      (in_if.attr_byte),
    .flash_phase_i    (in_if.flash_phase),
    .out_valid_i      (out_if.valid),
    .out_ready_i      (out_if.ready),
    .fb_index_i       (out_if.fb_index),
    .pixel_word_i     (out_if.pixel_word),
    .bitmap_addr_i    (out_if.bitmap_addr),
    .attr_addr_i      (out_if.attr_addr),
    .frame_last_i     (out_if.frame_last),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .mismatch_count_o (mismatches),
    .pending_words_o  (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // setup phase, then access phase, held until pready
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one cell item, entered and left at a falling edge
  task automatic send_cell(input logic [7:0] pb, input logic [7:0] ab, input logic fp);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.pixel_byte  <= pb;
    in_if.attr_byte   <= ab;
    in_if.flash_phase <= fp;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_cell(8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // block is idle once every word is out; a settle wait follows for margin
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleWait) @(negedge clk);
  endtask

  // {pixel byte, attribute, flash phase}: solid, flashing both phases, bright,
  // paper only, ink only, alternating patterns
  logic [16:0] directed_cells [NumDirected] = '{
    {8'h00, 8'h00, 1'b0}, {8'hFF, 8'hFF, 1'b0}, {8'hFF, 8'hFF, 1'b1},
    {8'h00, 8'hFF, 1'b1}, {8'h80, 8'h47, 1'b0}, {8'h01, 8'h38, 1'b0},
    {8'hAA, 8'hC7, 1'b1}, {8'h55, 8'hC7, 1'b0}, {8'hAA, 8'hB8, 1'b1},
    {8'h0F, 8'h7F, 1'b0}, {8'hF0, 8'h80, 1'b1}, {8'h3C, 8'h40, 1'b1},
    {8'hC3, 8'h07, 1'b0}, {8'hFF, 8'h00, 1'b1}, {8'h00, 8'h80, 1'b0},
    {8'h81, 8'hF8, 1'b1}, {8'h7E, 8'h3F, 1'b0}, {8'h18, 8'hC0, 1'b1},
    {8'hE7, 8'h78, 1'b0}, {8'h5A, 8'hFE, 1'b1}
  };

  // register settings per phase; line_words below 32 on purpose in some
  logic [14:0] phase_base [NumPhases] = '{
    15'd0, 15'd32767, 15'd2118, 15'd12345, 15'd100, 15'd32767, 15'd0, 15'd0
  };
  logic [7:0]  phase_lines [NumPhases] = '{
    8'd32, 8'd255, 8'd44, 8'd0, 8'd31, 8'd1, 8'd255, 8'd0
  };

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_if.valid       = 1'b0;
    in_if.pixel_byte  = '0;
    in_if.attr_byte   = '0;
    in_if.flash_phase = 1'b0;
    out_if.ready      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed cells at the reset settings, no idling
    foreach (directed_cells[i]) begin
      send_cell(directed_cells[i][16:9], directed_cells[i][8:1], directed_cells[i][0]);
    end

    // random phases: settings and idling pattern change together
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      if (p == NumPhases - 1) begin
        write_reg(RegFrameBase, 32'($urandom_range(32767)));
        write_reg(RegLineWords, 32'($urandom_range(255)));
      end else begin
        write_reg(RegFrameBase, 32'(phase_base[p]));
        write_reg(RegLineWords, 32'(phase_lines[p]));
      end
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 7; stall_pct = 7; end
      endcase
      send_random(PhaseItems);
    end

    // long hold-off on the output while items keep coming
    wait_idle();
    write_reg(RegFrameBase, 32'($urandom_range(32767)));
    write_reg(RegLineWords, 32'($urandom_range(32, 255)));
    idle_pct  = 0;
    stall_pct = 0;
    hold_left = HoldCycles;
    send_random(40);

    // top up to the item total at the widest settings
    wait_idle();
    write_reg(RegFrameBase, 32'd32767);
    write_reg(RegLineWords, 32'd255);
    while (items_sent < TotalItems) begin
      send_cell(8'($urandom), 8'($urandom), 1'($urandom));
    end

    wait_idle();
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
